>>> rtl/core/u8dfa_pkg.sv
package u8dfa_pkg;

   // One input item: a raw byte and the restart flag.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       restart;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [1:0]  status;
      logic [20:0] code_point;
      logic [3:0]  decoder_state;
   } rsp_type;

   // An item after classification, as it waits in the queue.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       restart;
      logic [3:0] byte_class;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   localparam int QueueDepth = 2;
   localparam int QueuePtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   localparam logic [3:0] StateAccept = 4'd0;
   localparam logic [3:0] StateReject = 4'd1;
   localparam logic [3:0] StateLast   = 4'd8;

   localparam logic [1:0] StatusIncomplete = 2'd0;
   localparam logic [1:0] StatusComplete   = 2'd1;
   localparam logic [1:0] StatusInvalid    = 2'd2;

   localparam logic [7:0] ContMask = 8'h3F;

   // Next state, indexed by current state and byte class.
   localparam logic [3:0] StepTable [0:8][0:15] = '{
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1,
        4'd1, 4'd1, 4'd4, 4'd6, 4'd1, 4'd1, 4'd1, 4'd1},
      '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
      '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0,
        4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
      '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
        4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
      '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
      '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
      '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
        4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
      '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
        4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
      '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
   };

   function automatic logic [3:0] classify(input logic [7:0] b);
      logic [3:0] cls;
      if (b < 8'h80) begin
         cls = 4'd0;
      end else if (b < 8'h90) begin
         cls = 4'd1;
      end else if (b < 8'hA0) begin
         cls = 4'd9;
      end else if (b < 8'hC0) begin
         cls = 4'd7;
      end else if (b < 8'hC2) begin
         cls = 4'd8;
      end else if (b < 8'hE0) begin
         cls = 4'd2;
      end else if (b == 8'hE0) begin
         cls = 4'd10;
      end else if (b == 8'hED) begin
         cls = 4'd4;
      end else if (b < 8'hF0) begin
         cls = 4'd3;
      end else if (b == 8'hF0) begin
         cls = 4'd11;
      end else if (b < 8'hF4) begin
         cls = 4'd6;
      end else if (b == 8'hF4) begin
         cls = 4'd5;
      end else begin
         cls = 4'd8;
      end
      return cls;
   endfunction

endpackage

>>> rtl/core/utf8_dfa_decoder_core.sv
// Strict UTF-8 decoder: one byte in, one status/code point result out.
// A byte accepted is written into the queue, then registered into the result register that drives rsp_valid.
// Throughput: one byte per cycle while rsp_stall is low; the DFA step reads the state register and writes it back.
// A two-entry queue between the classifier and the DFA holds bytes while the result is stalled.
// Reset (synchronous, active high) empties the queue and output, and puts the DFA in accept.
module utf8_dfa_decoder_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  u8dfa_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output u8dfa_pkg::rsp_type   rsp_data
);

   u8dfa_pkg::queue_status_type  queue_status;
   u8dfa_pkg::entry_type         push_entry;
   u8dfa_pkg::entry_type         head;
   logic                         push;
   logic                         pop;

   u8dfa_front u_front (
      .req_valid    (req_valid),
      .req_data     (req_data),
      .queue_status (queue_status),
      .req_stall    (req_stall),
      .push         (push),
      .push_entry   (push_entry)
   );

   u8dfa_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_entry   (push_entry),
      .pop          (pop),
      .head         (head),
      .queue_status (queue_status)
   );

   u8dfa_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

endmodule

>>> rtl/core/u8dfa_front.sv
module u8dfa_front (
   input  logic                         req_valid,
   input  u8dfa_pkg::req_type           req_data,
   input  u8dfa_pkg::queue_status_type  queue_status,
   output logic                         req_stall,
   output logic                         push,
   output u8dfa_pkg::entry_type         push_entry
);

   // The byte class is worked out here so that the back end only does the table step.
   always_comb begin
      req_stall             = queue_status.full;
      push                  = req_valid & ~queue_status.full;
      push_entry.data_byte  = req_data.data_byte;
      push_entry.restart    = req_data.restart;
      push_entry.byte_class = u8dfa_pkg::classify(req_data.data_byte);
   end

endmodule

>>> rtl/core/u8dfa_queue.sv
module u8dfa_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  u8dfa_pkg::entry_type         push_entry,
   input  logic                         pop,
   output u8dfa_pkg::entry_type         head,
   output u8dfa_pkg::queue_status_type  queue_status
);

   localparam logic [u8dfa_pkg::QueuePtrWidth-1:0] LastPtr =
      u8dfa_pkg::QueuePtrWidth'(u8dfa_pkg::QueueDepth - 1);
   localparam logic [u8dfa_pkg::QueueCountWidth-1:0] FullCount =
      u8dfa_pkg::QueueCountWidth'(u8dfa_pkg::QueueDepth);

   u8dfa_pkg::entry_type entry_ff [u8dfa_pkg::QueueDepth];
   logic [u8dfa_pkg::QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [u8dfa_pkg::QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [u8dfa_pkg::QueueCountWidth-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_comb begin
      head               = entry_ff[rd_ptr_ff];
      queue_status.full  = (count_ff == FullCount);
      queue_status.empty = (count_ff == '0);
   end

   property p_no_overflow;
      @(posedge clock) disable iff (reset) queue_status.full |-> !push;
   endproperty
   a_no_overflow: assert property (p_no_overflow)
      else $error("item pushed into a full queue");

   property p_no_underflow;
      @(posedge clock) disable iff (reset) queue_status.empty |-> !pop;
   endproperty
   a_no_underflow: assert property (p_no_underflow)
      else $error("item popped from an empty queue");

   property p_count_range;
      @(posedge clock) disable iff (reset) count_ff <= FullCount;
   endproperty
   a_count_range: assert property (p_count_range)
      else $error("queue count beyond its depth");

endmodule

>>> rtl/core/u8dfa_back.sv
module u8dfa_back (
   input  logic                         clock,
   input  logic                         reset,
   input  u8dfa_pkg::entry_type         head,
   input  u8dfa_pkg::queue_status_type  queue_status,
   output logic                         pop,
   input  logic                         rsp_stall,
   output logic                         rsp_valid,
   output u8dfa_pkg::rsp_type           rsp_data
);

   logic [3:0]          dfa_state_ff, dfa_state_in;
   logic [20:0]         partial_ff, partial_in;
   logic                rsp_valid_ff, rsp_valid_in;
   u8dfa_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic [3:0]  cur_state;
   logic [20:0] cur_partial;
   logic [3:0]  next_state;
   logic        load;

   always_comb begin
      load = ~rsp_valid_ff | ~rsp_stall;
      pop  = load & ~queue_status.empty;

      // A restart acts as though the decoder had just come out of reset.
      cur_state   = head.restart ? u8dfa_pkg::StateAccept : dfa_state_ff;
      cur_partial = head.restart ? '0 : partial_ff;

      if (cur_state != u8dfa_pkg::StateAccept) begin
         partial_in = {cur_partial[14:0], head.data_byte[5:0] & u8dfa_pkg::ContMask[5:0]};
      end else begin
         partial_in = {13'd0, (8'hFF >> head.byte_class) & head.data_byte};
      end

      if (cur_state > u8dfa_pkg::StateLast) begin
         next_state = u8dfa_pkg::StateReject;
      end else begin
         next_state = u8dfa_pkg::StepTable[cur_state][head.byte_class];
      end
      dfa_state_in = next_state;

      rsp_data_in.decoder_state = next_state;
      rsp_data_in.code_point    = '0;
      if (next_state == u8dfa_pkg::StateAccept) begin
         rsp_data_in.status     = u8dfa_pkg::StatusComplete;
         rsp_data_in.code_point = partial_in;
      end else if (next_state == u8dfa_pkg::StateReject) begin
         rsp_data_in.status = u8dfa_pkg::StatusInvalid;
      end else begin
         rsp_data_in.status = u8dfa_pkg::StatusIncomplete;
      end

      rsp_valid_in = load ? pop : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dfa_state_ff <= u8dfa_pkg::StateAccept;
         partial_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            dfa_state_ff <= dfa_state_in;
            partial_ff   <= partial_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   property p_reject_sticky;
      @(posedge clock) disable iff (reset)
         (pop && !head.restart && dfa_state_ff == u8dfa_pkg::StateReject)
         |=> (dfa_state_ff == u8dfa_pkg::StateReject);
   endproperty
   a_reject_sticky: assert property (p_reject_sticky)
      else $error("decoder left the reject state without a restart");

   property p_status_matches_state;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff |->
            ((rsp_data_ff.status == u8dfa_pkg::StatusComplete) ==
             (rsp_data_ff.decoder_state == u8dfa_pkg::StateAccept));
   endproperty
   a_status_matches_state: assert property (p_status_matches_state)
      else $error("result status disagrees with decoder state");

   property p_code_point_cleared;
      @(posedge clock) disable iff (reset)
         (rsp_valid_ff && rsp_data_ff.status != u8dfa_pkg::StatusComplete)
         |-> (rsp_data_ff.code_point == '0);
   endproperty
   a_code_point_cleared: assert property (p_code_point_cleared)
      else $error("code point not cleared on an incomplete or invalid item");

endmodule
